/* sv/tfd_pkg.sv */
// Shared types, constants and register codes for the thermal foldback derating block.
package tfd_pkg;

    // Width of the wrapping millisecond time base.
    localparam int TIME_WIDTH = 32;
    // The timestamp port and the interval register are fixed at 32 bits.
    localparam int PORT_TIME_WIDTH = 32;
    // Width at which elapsed time and the interval are compared.
    localparam int CMP_WIDTH = (TIME_WIDTH > PORT_TIME_WIDTH) ? TIME_WIDTH : PORT_TIME_WIDTH;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 32;

    // Configuration register indices.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_START_TEMP   = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RESUME_TEMP  = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIN_PERCENT  = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_STEP_PERCENT = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_INTERVAL_MS  = 3'd4;

    // Full output, no derating.
    localparam logic [6:0] FULL_PERCENT = 7'd100;

    // Register reset values.
    localparam logic signed [15:0] START_TEMP_RST   = 16'sd70;
    localparam logic signed [15:0] RESUME_TEMP_RST  = 16'sd60;
    localparam logic [6:0]         MIN_PERCENT_RST  = 7'd30;
    localparam logic [6:0]         STEP_PERCENT_RST = 7'd5;
    localparam logic [31:0]        INTERVAL_MS_RST  = 32'd4000;

    typedef logic [TIME_WIDTH-1:0] time_t;
    typedef logic [CMP_WIDTH-1:0]  cmp_t;

    // Configuration as seen by the step logic.
    typedef struct packed {
        logic signed [15:0] start_temp;
        logic signed [15:0] resume_temp;
        logic [6:0]         min_percent;
        logic [6:0]         step_percent;
        logic [31:0]        interval_ms;
    } cfg_t;

    // One accepted input beat.
    typedef struct packed {
        logic               sensor_ok;
        logic               overtemp_fault;
        logic signed [15:0] sensed_temp;
        logic [31:0]        now_ms;
    } item_t;

    // One result beat.
    typedef struct packed {
        logic [6:0] derate;
        logic       active;
        logic       changed;
    } res_t;

endpackage

/* sv/tfd_cfg.sv */
// Configuration register file for the thermal foldback derating block.
module tfd_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tfd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [tfd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    output tfd_pkg::cfg_t                       cfg
);

    tfd_pkg::cfg_t cfg_reg;

    // Decode the index and update the addressed register; unknown indices are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_temp   <= tfd_pkg::START_TEMP_RST;
            cfg_reg.resume_temp  <= tfd_pkg::RESUME_TEMP_RST;
            cfg_reg.min_percent  <= tfd_pkg::MIN_PERCENT_RST;
            cfg_reg.step_percent <= tfd_pkg::STEP_PERCENT_RST;
            cfg_reg.interval_ms  <= tfd_pkg::INTERVAL_MS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tfd_pkg::REG_START_TEMP:   cfg_reg.start_temp   <= $signed(cfg_data[15:0]);
                tfd_pkg::REG_RESUME_TEMP:  cfg_reg.resume_temp  <= $signed(cfg_data[15:0]);
                tfd_pkg::REG_MIN_PERCENT:  cfg_reg.min_percent  <= cfg_data[6:0];
                tfd_pkg::REG_STEP_PERCENT: cfg_reg.step_percent <= cfg_data[6:0];
                tfd_pkg::REG_INTERVAL_MS:  cfg_reg.interval_ms  <= cfg_data[31:0];
                default:                   ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* sv/tfd_core.sv */
// Derate state registers and the single-pass update logic for one beat.
module tfd_core
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  tfd_pkg::item_t item,
    input  tfd_pkg::cfg_t  cfg,
    output tfd_pkg::res_t  res
);

    logic [6:0]          derate_reg;
    logic [6:0]          derate_next;
    logic                active_reg;
    logic                active_next;
    tfd_pkg::time_t      last_step_reg;
    tfd_pkg::time_t      last_step_next;

    logic [6:0]          eff_min;
    logic                hot;
    logic                cool;
    tfd_pkg::time_t      now_t;
    tfd_pkg::time_t      elapsed;
    logic                step_ok;
    logic signed [8:0]   down_s;
    logic signed [8:0]   up_s;
    logic signed [8:0]   stepped;
    logic [6:0]          clamped;

    // Band limits and temperature classification.
    assign eff_min = (cfg.min_percent > tfd_pkg::FULL_PERCENT) ? tfd_pkg::FULL_PERCENT
                                                               : cfg.min_percent;
    assign hot  = item.sensed_temp >= cfg.start_temp;
    assign cool = item.sensed_temp < cfg.resume_temp;

    // Pacing: elapsed time wraps at the width of the time base.
    assign now_t   = tfd_pkg::time_t'(item.now_ms);
    assign elapsed = now_t - last_step_reg;
    assign step_ok = tfd_pkg::cmp_t'(elapsed) >= tfd_pkg::cmp_t'(cfg.interval_ms);

    // Candidate step in either direction, clamped to the band.
    assign down_s  = $signed({2'b00, derate_reg}) - $signed({2'b00, cfg.step_percent});
    assign up_s    = $signed({2'b00, derate_reg}) + $signed({2'b00, cfg.step_percent});
    assign stepped = hot ? down_s : up_s;

    always_comb
    begin
        if (stepped > $signed({2'b00, tfd_pkg::FULL_PERCENT}))
            clamped = tfd_pkg::FULL_PERCENT;
        else if (stepped < $signed({2'b00, eff_min}))
            clamped = eff_min;
        else
            clamped = stepped[6:0];
    end

    // Next state: fault first, then deadband, rail checks and the paced step.
    always_comb
    begin
        derate_next    = derate_reg;
        active_next    = active_reg;
        last_step_next = last_step_reg;
        if (!item.sensor_ok || item.overtemp_fault)
        begin
            derate_next = tfd_pkg::FULL_PERCENT;
            active_next = 1'b0;
        end
        else if (!hot && !cool)
        begin
            active_next = derate_reg < tfd_pkg::FULL_PERCENT;
        end
        else if (hot && derate_reg == eff_min)
        begin
            active_next = 1'b1;
        end
        else if (cool && derate_reg == tfd_pkg::FULL_PERCENT)
        begin
            active_next = 1'b0;
        end
        else if (step_ok)
        begin
            last_step_next = now_t;
            derate_next    = clamped;
            active_next    = clamped < tfd_pkg::FULL_PERCENT;
        end
    end

    // State advances only when the beat moves on to the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            derate_reg    <= tfd_pkg::FULL_PERCENT;
            active_reg    <= 1'b0;
            last_step_reg <= '0;
        end
        else if (fire)
        begin
            derate_reg    <= derate_next;
            active_reg    <= active_next;
            last_step_reg <= last_step_next;
        end
    end

    assign res.derate  = derate_next;
    assign res.active  = active_next;
    assign res.changed = derate_next != derate_reg;

endmodule

/* sv/thermal_foldback_derate.sv */
// An accepted beat reaches the output through the input register and then the result register.
// Throughput: one beat per cycle while out_ready is high; the derate state loop closes in tfd_core.
// An empty input register accepts a new beat even while the result register holds an untaken result.
// Reset: derate 100, inactive, last step time 0, registers at their reset values, both stages empty.
// Top level of the thermal foldback derating block.
module thermal_foldback_derate
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tfd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [tfd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                sensor_ok,
    input  logic                                overtemp_fault,
    input  logic signed [15:0]                  sensed_temp,
    input  logic [31:0]                         now_ms,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [6:0]                          derate_out,
    output logic                                active_out,
    output logic                                changed
);

    tfd_pkg::cfg_t  cfg;
    tfd_pkg::item_t item_reg;
    logic           item_valid_reg;
    tfd_pkg::res_t  res;
    tfd_pkg::res_t  res_reg;
    logic           res_valid_reg;
    logic           advance;

    tfd_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The held beat moves on when the result register is empty or being emptied.
    assign advance  = item_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;

    tfd_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    // Input register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_ready)
            item_valid_reg <= in_valid;
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.sensor_ok      <= sensor_ok;
            item_reg.overtemp_fault <= overtemp_fault;
            item_reg.sensed_temp    <= sensed_temp;
            item_reg.now_ms         <= now_ms;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= 1'b1;
        else if (out_ready)
            res_valid_reg <= 1'b0;
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res;
    end

    assign out_valid  = res_valid_reg;
    assign derate_out = res_reg.derate;
    assign active_out = res_reg.active;
    assign changed    = res_reg.changed;

`ifndef SYNTHESIS
    // A delivered derate never exceeds full output.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> derate_out <= tfd_pkg::FULL_PERCENT)
        else $error("derate above full output");

    // A changed derate leaves the active flag consistent with the new value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && changed) |-> (active_out == (derate_out != tfd_pkg::FULL_PERCENT)))
        else $error("active flag inconsistent after a derate change");

    // A held beat that could not move on is still held next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && !advance) |=> item_valid_reg)
        else $error("held input beat lost");

    // A result waiting for the consumer stays and is not overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !out_ready) |=> (res_valid_reg && $stable(res_reg)))
        else $error("pending result disturbed");
`endif

endmodule
